// ===== rtl/jmrs_pkg.sv =====
// Package for the joint motion rest and stuck monitor.
// Holds field widths, parameter defaults, register reset values,
// the register index codes and the configuration struct.
package jmrs_pkg;

    // Parameter defaults
    localparam int DEF_WINDOW_DEPTH = 8;
    localparam int DEF_ANGLE_BITS   = 16;

    // Fixed field widths
    localparam int CFG_LIMIT_W = 15;
    localparam int CFG_TIME_W  = 16;
    localparam int TIME_W      = 32;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // Register reset values
    localparam logic [CFG_LIMIT_W-1:0] RST_TARGET_DISTANCE = 15'd200;
    localparam logic [CFG_LIMIT_W-1:0] RST_REST_STAND      = 15'd20;
    localparam logic [CFG_LIMIT_W-1:0] RST_REST_WALK       = 15'd40;
    localparam logic [CFG_TIME_W-1:0]  RST_STUCK_TIME      = 16'd1000;

    // Register index codes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET_DISTANCE = 8'd0,
        CFG_REST_STAND      = 8'd1,
        CFG_REST_WALK       = 8'd2,
        CFG_STUCK_TIME      = 8'd3
    } cfg_index_t;

    // Current register contents, shared by both stages
    typedef struct packed {
        logic [CFG_LIMIT_W-1:0] target_limit;
        logic [CFG_LIMIT_W-1:0] rest_stand;
        logic [CFG_LIMIT_W-1:0] rest_walk;
        logic [CFG_TIME_W-1:0]  stuck_ms;
    } cfg_t;

endpackage

// ===== rtl/jmrs_window.sv =====
// Change window stage: per-frame angle change, running sums over the
// window memory, fill count, target error and scaled rest limit.
// Depends on jmrs_pkg.
module jmrs_window #(
    parameter int WINDOW_DEPTH = jmrs_pkg::DEF_WINDOW_DEPTH,
    parameter int ANGLE_BITS   = jmrs_pkg::DEF_ANGLE_BITS
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      en,
    input  logic signed [ANGLE_BITS-1:0]              yaw,
    input  logic signed [ANGLE_BITS-1:0]              pitch,
    input  logic signed [ANGLE_BITS-1:0]              yaw_goal,
    input  logic signed [ANGLE_BITS-1:0]              pitch_goal,
    input  logic                                      walking,
    input  logic [jmrs_pkg::TIME_W-1:0]               now,
    input  jmrs_pkg::cfg_t                            cfg,
    output logic signed [ANGLE_BITS+$clog2(WINDOW_DEPTH):0] yaw_sum_out,
    output logic signed [ANGLE_BITS+$clog2(WINDOW_DEPTH):0] pitch_sum_out,
    output logic                                      full_out,
    output logic signed [ANGLE_BITS:0]                yaw_err_out,
    output logic signed [ANGLE_BITS:0]                pitch_err_out,
    output logic [jmrs_pkg::CFG_LIMIT_W+$clog2(WINDOW_DEPTH)-1:0] rest_lim_out,
    output logic [jmrs_pkg::TIME_W-1:0]               now_out
);
    import jmrs_pkg::*;

    localparam int CHG_W  = ANGLE_BITS + 1;
    localparam int SUM_W  = CHG_W + $clog2(WINDOW_DEPTH);
    localparam int PTR_W  = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int RLIM_W = CFG_LIMIT_W + $clog2(WINDOW_DEPTH);

    // Window state
    logic [PTR_W-1:0]             ptr_reg;
    logic [PTR_W-1:0]             ptr_next;
    logic [FILL_W-1:0]            fill_reg;
    logic [FILL_W-1:0]            fill_next;
    logic signed [ANGLE_BITS-1:0] prev_yaw_reg;
    logic signed [ANGLE_BITS-1:0] prev_pitch_reg;
    logic signed [SUM_W-1:0]      yaw_sum_reg;
    logic signed [SUM_W-1:0]      pitch_sum_reg;
    logic signed [SUM_W-1:0]      yaw_sum_next;
    logic signed [SUM_W-1:0]      pitch_sum_next;

    // Change memory, one entry holds both axes
    logic [2*CHG_W-1:0] chg_mem [WINDOW_DEPTH];
    logic [2*CHG_W-1:0] rd_reg;

    logic                    full_now;
    logic signed [CHG_W-1:0] dyaw;
    logic signed [CHG_W-1:0] dpitch;
    logic signed [CHG_W-1:0] old_yaw;
    logic signed [CHG_W-1:0] old_pitch;
    logic [CFG_LIMIT_W-1:0]  rest_sel;

    // Entries only hold data once the window has wrapped
    assign full_now  = (fill_reg == FILL_W'(WINDOW_DEPTH));
    assign old_yaw   = full_now ? $signed(rd_reg[2*CHG_W-1:CHG_W]) : '0;
    assign old_pitch = full_now ? $signed(rd_reg[CHG_W-1:0]) : '0;

    // Change is previous minus current
    assign dyaw   = $signed({prev_yaw_reg[ANGLE_BITS-1], prev_yaw_reg})
                  - $signed({yaw[ANGLE_BITS-1], yaw});
    assign dpitch = $signed({prev_pitch_reg[ANGLE_BITS-1], prev_pitch_reg})
                  - $signed({pitch[ANGLE_BITS-1], pitch});

    // Advance running sums: add the new change, drop the oldest
    assign yaw_sum_next   = yaw_sum_reg + SUM_W'(dyaw) - SUM_W'(old_yaw);
    assign pitch_sum_next = pitch_sum_reg + SUM_W'(dpitch) - SUM_W'(old_pitch);

    assign ptr_next  = (ptr_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign fill_next = full_now ? fill_reg : fill_reg + 1'b1;
    assign rest_sel  = walking ? cfg.rest_walk : cfg.rest_stand;

    // Update window state on each item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg        <= '0;
            fill_reg       <= '0;
            prev_yaw_reg   <= '0;
            prev_pitch_reg <= '0;
            yaw_sum_reg    <= '0;
            pitch_sum_reg  <= '0;
        end else if (en) begin
            ptr_reg        <= ptr_next;
            fill_reg       <= fill_next;
            prev_yaw_reg   <= yaw;
            prev_pitch_reg <= pitch;
            yaw_sum_reg    <= yaw_sum_next;
            pitch_sum_reg  <= pitch_sum_next;
        end
    end

    // Write the new change, prefetch the slot used by the next item
    always_ff @(posedge aclk) begin
        if (en) begin
            chg_mem[ptr_reg] <= {dyaw, dpitch};
            rd_reg           <= chg_mem[ptr_next];
        end
    end

    // Stage register toward the judge stage
    always_ff @(posedge aclk) begin
        if (en) begin
            yaw_sum_out   <= yaw_sum_next;
            pitch_sum_out <= pitch_sum_next;
            full_out      <= (fill_next == FILL_W'(WINDOW_DEPTH));
            yaw_err_out   <= $signed({yaw_goal[ANGLE_BITS-1], yaw_goal})
                           - $signed({yaw[ANGLE_BITS-1], yaw});
            pitch_err_out <= $signed({pitch_goal[ANGLE_BITS-1], pitch_goal})
                           - $signed({pitch[ANGLE_BITS-1], pitch});
            rest_lim_out  <= RLIM_W'(rest_sel) * RLIM_W'(WINDOW_DEPTH);
            now_out       <= now;
        end
    end

endmodule

// ===== rtl/jmrs_judge.sv =====
// Judge stage: squared-distance tests for target and rest, stuck timer
// and the result register.
// Depends on jmrs_pkg.
module jmrs_judge #(
    parameter int WINDOW_DEPTH = jmrs_pkg::DEF_WINDOW_DEPTH,
    parameter int ANGLE_BITS   = jmrs_pkg::DEF_ANGLE_BITS
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      en,
    input  logic signed [ANGLE_BITS+$clog2(WINDOW_DEPTH):0] yaw_sum,
    input  logic signed [ANGLE_BITS+$clog2(WINDOW_DEPTH):0] pitch_sum,
    input  logic                                      full,
    input  logic signed [ANGLE_BITS:0]                yaw_err,
    input  logic signed [ANGLE_BITS:0]                pitch_err,
    input  logic [jmrs_pkg::CFG_LIMIT_W+$clog2(WINDOW_DEPTH)-1:0] rest_lim,
    input  logic [jmrs_pkg::TIME_W-1:0]               now,
    input  jmrs_pkg::cfg_t                            cfg,
    output logic                                      on_target_reg,
    output logic                                      at_rest_reg,
    output logic                                      stuck_reg
);
    import jmrs_pkg::*;

    localparam int ERR_W  = ANGLE_BITS + 1;
    localparam int SUM_W  = ERR_W + $clog2(WINDOW_DEPTH);
    localparam int RLIM_W = CFG_LIMIT_W + $clog2(WINDOW_DEPTH);
    localparam int DCMP_W = (ERR_W > CFG_LIMIT_W) ? ERR_W : CFG_LIMIT_W;
    localparam int RCMP_W = (SUM_W > RLIM_W) ? SUM_W : RLIM_W;
    localparam int DSQ_W  = 2 * CFG_LIMIT_W + 1;
    localparam int RSQ_W  = 2 * RLIM_W + 1;

    logic [ERR_W-1:0]         yaw_err_mag;
    logic [ERR_W-1:0]         pitch_err_mag;
    logic [SUM_W-1:0]         yaw_sum_mag;
    logic [SUM_W-1:0]         pitch_sum_mag;
    logic [CFG_LIMIT_W-1:0]   yaw_err_op;
    logic [CFG_LIMIT_W-1:0]   pitch_err_op;
    logic [RLIM_W-1:0]        yaw_sum_op;
    logic [RLIM_W-1:0]        pitch_sum_op;
    logic [2*CFG_LIMIT_W-1:0] yaw_err_sq;
    logic [2*CFG_LIMIT_W-1:0] pitch_err_sq;
    logic [2*CFG_LIMIT_W-1:0] target_lim_sq;
    logic [2*RLIM_W-1:0]      yaw_sum_sq;
    logic [2*RLIM_W-1:0]      pitch_sum_sq;
    logic [2*RLIM_W-1:0]      rest_lim_sq;
    logic                     dist_in_box;
    logic                     rest_in_box;
    logic                     reached;
    logic                     rest;
    logic [TIME_W-1:0]        last_move_reg;
    logic [TIME_W-1:0]        elapsed;
    logic                     overdue;

    // Magnitudes
    assign yaw_err_mag   = yaw_err[ERR_W-1] ? ERR_W'(-yaw_err) : ERR_W'(yaw_err);
    assign pitch_err_mag = pitch_err[ERR_W-1] ? ERR_W'(-pitch_err) : ERR_W'(pitch_err);
    assign yaw_sum_mag   = yaw_sum[SUM_W-1] ? SUM_W'(-yaw_sum) : SUM_W'(yaw_sum);
    assign pitch_sum_mag = pitch_sum[SUM_W-1] ? SUM_W'(-pitch_sum) : SUM_W'(pitch_sum);

    // Each axis must be below the limit before the squares matter
    assign dist_in_box = (DCMP_W'(yaw_err_mag) < DCMP_W'(cfg.target_limit))
                      && (DCMP_W'(pitch_err_mag) < DCMP_W'(cfg.target_limit));
    assign rest_in_box = (RCMP_W'(yaw_sum_mag) < RCMP_W'(rest_lim))
                      && (RCMP_W'(pitch_sum_mag) < RCMP_W'(rest_lim));

    // Inside the box the magnitudes fit the limit width
    assign yaw_err_op   = CFG_LIMIT_W'(DCMP_W'(yaw_err_mag));
    assign pitch_err_op = CFG_LIMIT_W'(DCMP_W'(pitch_err_mag));
    assign yaw_sum_op   = RLIM_W'(RCMP_W'(yaw_sum_mag));
    assign pitch_sum_op = RLIM_W'(RCMP_W'(pitch_sum_mag));

    assign yaw_err_sq    = yaw_err_op * yaw_err_op;
    assign pitch_err_sq  = pitch_err_op * pitch_err_op;
    assign target_lim_sq = cfg.target_limit * cfg.target_limit;
    assign yaw_sum_sq    = yaw_sum_op * yaw_sum_op;
    assign pitch_sum_sq  = pitch_sum_op * pitch_sum_op;
    assign rest_lim_sq   = rest_lim * rest_lim;

    assign reached = dist_in_box
        && ((DSQ_W'(yaw_err_sq) + DSQ_W'(pitch_err_sq)) < DSQ_W'(target_lim_sq));
    assign rest = full && rest_in_box
        && ((RSQ_W'(yaw_sum_sq) + RSQ_W'(pitch_sum_sq)) < RSQ_W'(rest_lim_sq));

    // Elapsed time wraps modulo the timestamp width
    assign elapsed = now - last_move_reg;
    assign overdue = elapsed > TIME_W'(cfg.stuck_ms);

    // Set stuck once overdue while off target at rest, else clear and renew time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stuck_reg     <= 1'b0;
            last_move_reg <= '0;
        end else if (en) begin
            if (!reached && rest) begin
                if (overdue) begin
                    stuck_reg <= 1'b1;
                end
            end else begin
                stuck_reg     <= 1'b0;
                last_move_reg <= now;
            end
        end
    end

    // Result flags
    always_ff @(posedge aclk) begin
        if (en) begin
            on_target_reg <= reached;
            at_rest_reg   <= rest;
        end
    end

endmodule

// ===== rtl/joint_motion_rest_stuck_monitor_core.sv =====
// Top level of the joint motion rest and stuck monitor: ports, register
// file, input register and pipeline handshake.
// Depends on jmrs_pkg, jmrs_window and jmrs_judge.
//
//   channel  direction  handshake             payload
//   s_       in         s_valid / s_ready     measured and goal angles, walking, time
//   m_       out        m_valid / m_ready     on_target, at_rest, stuck
//   cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Three register stages: input register, window stage, result register.
// One item per cycle sustained while m_ready is high; an accepted item passes
// the window stage and the result register before m_valid rises. The window
// and stuck state each update as an item advances. A stalled output holds its
// item; earlier stages keep filling until the pipeline is full, then s_ready
// drops. cfg_ready is always high. Synchronous active-low reset clears the
// window, the stuck timer and restores register defaults.
module joint_motion_rest_stuck_monitor_core #(
    parameter int WINDOW_DEPTH = jmrs_pkg::DEF_WINDOW_DEPTH,
    parameter int ANGLE_BITS   = jmrs_pkg::DEF_ANGLE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ANGLE_BITS-1:0]        s_yaw_measured,
    input  logic signed [ANGLE_BITS-1:0]        s_pitch_measured,
    input  logic signed [ANGLE_BITS-1:0]        s_yaw_goal,
    input  logic signed [ANGLE_BITS-1:0]        s_pitch_goal,
    input  logic                                s_walking,
    input  logic [jmrs_pkg::TIME_W-1:0]         s_frame_time_ms,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_on_target,
    output logic                                m_at_rest,
    output logic                                m_stuck,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jmrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [jmrs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import jmrs_pkg::*;

    localparam int SUM_W  = ANGLE_BITS + 1 + $clog2(WINDOW_DEPTH);
    localparam int RLIM_W = CFG_LIMIT_W + $clog2(WINDOW_DEPTH);

    cfg_t cfg_reg;

    // Input register
    logic                         in_valid_reg;
    logic signed [ANGLE_BITS-1:0] in_yaw_reg;
    logic signed [ANGLE_BITS-1:0] in_pitch_reg;
    logic signed [ANGLE_BITS-1:0] in_yaw_goal_reg;
    logic signed [ANGLE_BITS-1:0] in_pitch_goal_reg;
    logic                         in_walking_reg;
    logic [TIME_W-1:0]            in_time_reg;

    // Window stage outputs
    logic                         mid_valid_reg;
    logic signed [SUM_W-1:0]      mid_yaw_sum;
    logic signed [SUM_W-1:0]      mid_pitch_sum;
    logic                         mid_full;
    logic signed [ANGLE_BITS:0]   mid_yaw_err;
    logic signed [ANGLE_BITS:0]   mid_pitch_err;
    logic [RLIM_W-1:0]            mid_rest_lim;
    logic [TIME_W-1:0]            mid_time;

    logic out_valid_reg;
    logic out_free;
    logic mid_free;
    logic mid_adv;
    logic out_adv;

    // Stage handshake: a stage takes an item when it is empty or drains
    assign out_free = !out_valid_reg || m_ready;
    assign mid_free = !mid_valid_reg || out_free;
    assign s_ready  = !in_valid_reg || mid_free;
    assign mid_adv  = in_valid_reg && mid_free;
    assign out_adv  = mid_valid_reg && out_free;

    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;

    // Register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_limit <= RST_TARGET_DISTANCE;
            cfg_reg.rest_stand   <= RST_REST_STAND;
            cfg_reg.rest_walk    <= RST_REST_WALK;
            cfg_reg.stuck_ms     <= RST_STUCK_TIME;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TARGET_DISTANCE: cfg_reg.target_limit <= cfg_data[CFG_LIMIT_W-1:0];
                CFG_REST_STAND:      cfg_reg.rest_stand   <= cfg_data[CFG_LIMIT_W-1:0];
                CFG_REST_WALK:       cfg_reg.rest_walk    <= cfg_data[CFG_LIMIT_W-1:0];
                CFG_STUCK_TIME:      cfg_reg.stuck_ms     <= cfg_data[CFG_TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (mid_free) begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_free) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    // Capture an accepted item
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_yaw_reg        <= s_yaw_measured;
            in_pitch_reg      <= s_pitch_measured;
            in_yaw_goal_reg   <= s_yaw_goal;
            in_pitch_goal_reg <= s_pitch_goal;
            in_walking_reg    <= s_walking;
            in_time_reg       <= s_frame_time_ms;
        end
    end

    jmrs_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_window (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (mid_adv),
        .yaw           (in_yaw_reg),
        .pitch         (in_pitch_reg),
        .yaw_goal      (in_yaw_goal_reg),
        .pitch_goal    (in_pitch_goal_reg),
        .walking       (in_walking_reg),
        .now           (in_time_reg),
        .cfg           (cfg_reg),
        .yaw_sum_out   (mid_yaw_sum),
        .pitch_sum_out (mid_pitch_sum),
        .full_out      (mid_full),
        .yaw_err_out   (mid_yaw_err),
        .pitch_err_out (mid_pitch_err),
        .rest_lim_out  (mid_rest_lim),
        .now_out       (mid_time)
    );

    jmrs_judge #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_judge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (out_adv),
        .yaw_sum       (mid_yaw_sum),
        .pitch_sum     (mid_pitch_sum),
        .full          (mid_full),
        .yaw_err       (mid_yaw_err),
        .pitch_err     (mid_pitch_err),
        .rest_lim      (mid_rest_lim),
        .now           (mid_time),
        .cfg           (cfg_reg),
        .on_target_reg (m_on_target),
        .at_rest_reg   (m_at_rest),
        .stuck_reg     (m_stuck)
    );

endmodule
